/* src/fbp_pkg.sv */
package fbp_pkg;

  localparam int unsigned ThrBits = 16;
  localparam int unsigned DimRegBits = 14;
  localparam int unsigned ConfBits = 16;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned FracShift = 16;

  localparam logic [CfgIdxBits-1:0] REG_SCORE_THRESHOLD = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_IMAGE_WIDTH = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [ThrBits-1:0] THR_RESET = 16'd32768;
  localparam logic [DimRegBits-1:0] WIDTH_RESET = 14'd640;
  localparam logic [DimRegBits-1:0] HEIGHT_RESET = 14'd480;

  localparam logic [FracShift-1:0] FRAC_X_LEFT = 16'd4391;
  localparam logic [FracShift-1:0] FRAC_Y_TOP = 16'd1835;
  localparam logic [FracShift-1:0] FRAC_W_GROW = 16'd9830;
  localparam logic [FracShift-1:0] FRAC_H_GROW = 16'd8520;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_RET  = 6'b000100,
    ST_SQD  = 6'b001000,
    ST_SQA  = 6'b010000,
    ST_CHK  = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    STEP_X  = 3'd0,
    STEP_Y  = 3'd1,
    STEP_W  = 3'd2,
    STEP_H  = 3'd3,
    STEP_DX = 3'd4,
    STEP_DY = 3'd5,
    STEP_GW = 3'd6,
    STEP_GH = 3'd7
  } step_e;

endpackage

/* src/fbp_mul.sv */
module fbp_mul #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 18
) (
  input  logic                        clk_i,
  input  logic signed [AW-1:0]        a_i,
  input  logic signed [BW-1:0]        b_i,
  output logic signed [AW+BW-1:0]     prod_o
);

  logic signed [AW+BW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

/* src/face_box_postprocess_core.sv */
// Face box post-processing. A detector record is taken while the block is idle; a record
// that is dropped (frame stopped or confidence below threshold) leaves the block idle, so
// the input stays free, while a record that passes occupies the block for eight passes
// through one shared signed multiplier (scaling left, top, width and height, then four
// fixed-fraction adjustments, each product registered in the multiplier before it is
// retired), the retire and squaring states, and a containment check that loads the output
// register only for a box inside the frame; the check waits while a previous box is still
// held stalled at the output. Configuration may be written only while the block is idle.
module face_box_postprocess_core #(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned DIM_BITS = 13
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fbp_pkg::CfgIdxBits-1:0]         cfg_idx_i,
  input  logic [fbp_pkg::CfgDataBits-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   frame_start_i,
  input  logic [fbp_pkg::ConfBits-1:0]           confidence_i,
  input  logic signed [COORD_FRAC_BITS+1:0]      left_norm_i,
  input  logic signed [COORD_FRAC_BITS+1:0]      top_norm_i,
  input  logic signed [COORD_FRAC_BITS+1:0]      right_norm_i,
  input  logic signed [COORD_FRAC_BITS+1:0]      bottom_norm_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [fbp_pkg::ConfBits-1:0]           box_confidence_o,
  output logic [DIM_BITS-1:0]                    box_x_o,
  output logic [DIM_BITS-1:0]                    box_y_o,
  output logic [DIM_BITS:0]                      box_width_o,
  output logic [DIM_BITS:0]                      box_height_o
);

  localparam int unsigned CW = COORD_FRAC_BITS + 2;
  localparam int unsigned DFW = COORD_FRAC_BITS + 3;
  localparam int unsigned VW = DIM_BITS + 5;
  localparam int unsigned MA = (DFW > VW) ? DFW : VW;
  localparam int unsigned MB = (DIM_BITS + 2 > fbp_pkg::FracShift + 1) ?
                               DIM_BITS + 2 : fbp_pkg::FracShift + 1;
  localparam int unsigned PW = MA + MB;
  localparam int unsigned LW = (DIM_BITS + 1 > fbp_pkg::DimRegBits) ?
                               DIM_BITS + 1 : fbp_pkg::DimRegBits;
  localparam logic [LW-1:0] DIM_LIMIT = LW'(1) << DIM_BITS;
  localparam logic [PW-1:0] BIAS_C = (PW'(1) << COORD_FRAC_BITS) - PW'(1);
  localparam logic [PW-1:0] BIAS_F = (PW'(1) << fbp_pkg::FracShift) - PW'(1);

  logic [fbp_pkg::ThrBits-1:0]    thr_q;
  logic [fbp_pkg::DimRegBits-1:0] img_w_q, img_h_q;

  fbp_pkg::state_e state_q, state_d;
  fbp_pkg::step_e  step_q, step_d, ret_q, ret_d;
  logic            ret_vld_q, ret_vld_d;
  logic            stopped_q, stopped_d;

  logic [fbp_pkg::ConfBits-1:0] conf_q;
  logic signed [CW-1:0]         l_q, t_q;
  logic signed [DFW-1:0]        dw_q, dh_q;
  logic [DIM_BITS:0]            wlim_q, hlim_q;
  logic [LW-1:0]                img_w_ext, img_h_ext;

  logic signed [VW-1:0] x_q, x_d, y_q, y_d, w_q, w_d, h_q, h_d;
  logic signed [VW-1:0] sq_d_q;
  logic                 sq_lt_q;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] biased_c, biased_f, shifted_c, shifted_f;
  logic signed [VW-1:0] ret_val;

  logic                 accept, stop_eff, below;
  logic signed [VW:0]   x_ext_sum, y_ext_sum, wlim_s, hlim_s;
  logic                 box_fail, out_free, load_out;

  logic                         out_vld_q;
  logic [fbp_pkg::ConfBits-1:0] oconf_q;
  logic [DIM_BITS-1:0]          ox_q, oy_q;
  logic [DIM_BITS:0]            ow_q, oh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= fbp_pkg::THR_RESET;
      img_w_q <= fbp_pkg::WIDTH_RESET;
      img_h_q <= fbp_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbp_pkg::REG_SCORE_THRESHOLD: thr_q <= cfg_wdata_i[fbp_pkg::ThrBits-1:0];
        fbp_pkg::REG_IMAGE_WIDTH:     img_w_q <= cfg_wdata_i[fbp_pkg::DimRegBits-1:0];
        fbp_pkg::REG_IMAGE_HEIGHT:    img_h_q <= cfg_wdata_i[fbp_pkg::DimRegBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != fbp_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign stop_eff   = stopped_q && !frame_start_i;
  assign below      = (confidence_i < thr_q);
  assign img_w_ext  = LW'(img_w_q);
  assign img_h_ext  = LW'(img_h_q);

  // Latch the record and clamped frame size
  always_ff @(posedge clk_i) begin
    if (accept) begin
      conf_q <= confidence_i;
      l_q    <= left_norm_i;
      t_q    <= top_norm_i;
      dw_q   <= DFW'(right_norm_i) - DFW'(left_norm_i);
      dh_q   <= DFW'(bottom_norm_i) - DFW'(top_norm_i);
      wlim_q <= (img_w_ext > DIM_LIMIT) ? DIM_LIMIT[DIM_BITS:0] : img_w_ext[DIM_BITS:0];
      hlim_q <= (img_h_ext > DIM_LIMIT) ? DIM_LIMIT[DIM_BITS:0] : img_h_ext[DIM_BITS:0];
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = MA'(l_q);
    mul_b = MB'(wlim_q);
    case (step_q)
      fbp_pkg::STEP_X: begin
        mul_a = MA'(l_q);
        mul_b = MB'(wlim_q);
      end
      fbp_pkg::STEP_Y: begin
        mul_a = MA'(t_q);
        mul_b = MB'(hlim_q);
      end
      fbp_pkg::STEP_W: begin
        mul_a = MA'(dw_q);
        mul_b = MB'(wlim_q);
      end
      fbp_pkg::STEP_H: begin
        mul_a = MA'(dh_q);
        mul_b = MB'(hlim_q);
      end
      fbp_pkg::STEP_DX: begin
        mul_a = MA'(w_q);
        mul_b = MB'(fbp_pkg::FRAC_X_LEFT);
      end
      fbp_pkg::STEP_DY: begin
        mul_a = MA'(h_q);
        mul_b = MB'(fbp_pkg::FRAC_Y_TOP);
      end
      fbp_pkg::STEP_GW: begin
        mul_a = MA'(w_q);
        mul_b = MB'(fbp_pkg::FRAC_W_GROW);
      end
      fbp_pkg::STEP_GH: begin
        mul_a = MA'(h_q);
        mul_b = MB'(fbp_pkg::FRAC_H_GROW);
      end
      default: ;
    endcase
  end

  fbp_mul #(
    .AW(MA),
    .BW(MB)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // Truncate toward zero
  assign biased_c  = prod + (prod[PW-1] ? BIAS_C : '0);
  assign biased_f  = prod + (prod[PW-1] ? BIAS_F : '0);
  assign shifted_c = biased_c >>> COORD_FRAC_BITS;
  assign shifted_f = biased_f >>> fbp_pkg::FracShift;
  assign ret_val   = (ret_q inside {fbp_pkg::STEP_X, fbp_pkg::STEP_Y,
                                    fbp_pkg::STEP_W, fbp_pkg::STEP_H}) ?
                     shifted_c[VW-1:0] : shifted_f[VW-1:0];

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    w_d = w_q;
    h_d = h_q;
    if (ret_vld_q) begin
      case (ret_q)
        fbp_pkg::STEP_X:  x_d = ret_val;
        fbp_pkg::STEP_Y:  y_d = ret_val;
        fbp_pkg::STEP_W:  w_d = ret_val;
        fbp_pkg::STEP_H:  h_d = ret_val;
        fbp_pkg::STEP_DX: x_d = x_q - ret_val;
        fbp_pkg::STEP_DY: y_d = y_q - ret_val;
        fbp_pkg::STEP_GW: w_d = w_q + ret_val;
        fbp_pkg::STEP_GH: h_d = h_q + ret_val;
        default: ;
      endcase
    end else if (state_q == fbp_pkg::ST_SQA) begin
      if (sq_lt_q) begin
        x_d = x_q - (sq_d_q >>> 1);
        w_d = h_q;
      end else begin
        y_d = y_q - (sq_d_q >>> 1);
        h_d = w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    w_q <= w_d;
    h_q <= h_d;
    if (state_q == fbp_pkg::ST_SQD) begin
      sq_lt_q <= (w_q < h_q);
      sq_d_q  <= (w_q < h_q) ? (h_q - w_q) : (w_q - h_q);
    end
  end

  assign x_ext_sum = (VW+1)'(x_q) + (VW+1)'(w_q);
  assign y_ext_sum = (VW+1)'(y_q) + (VW+1)'(h_q);
  assign wlim_s    = (VW+1)'(wlim_q);
  assign hlim_s    = (VW+1)'(hlim_q);
  assign box_fail  = (w_q <= 0) || (h_q <= 0) || (x_q < 0) || (y_q < 0) ||
                     (x_ext_sum > wlim_s) || (y_ext_sum > hlim_s);
  assign out_free  = !out_vld_q || !out_stall_i;
  assign load_out  = (state_q == fbp_pkg::ST_CHK) && out_free && !box_fail;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    ret_d     = step_q;
    ret_vld_d = 1'b0;
    stopped_d = stopped_q;
    case (state_q)
      fbp_pkg::ST_IDLE: begin
        step_d = fbp_pkg::STEP_X;
        if (accept) begin
          stopped_d = stop_eff || below;
          if (!stop_eff && !below) begin
            state_d = fbp_pkg::ST_MUL;
          end
        end
      end
      fbp_pkg::ST_MUL: begin
        ret_vld_d = 1'b1;
        if (step_q == fbp_pkg::STEP_GH) begin
          state_d = fbp_pkg::ST_RET;
        end else begin
          step_d = fbp_pkg::step_e'(step_q + 3'd1);
        end
      end
      fbp_pkg::ST_RET: state_d = fbp_pkg::ST_SQD;
      fbp_pkg::ST_SQD: state_d = fbp_pkg::ST_SQA;
      fbp_pkg::ST_SQA: state_d = fbp_pkg::ST_CHK;
      fbp_pkg::ST_CHK: begin
        if (out_free) begin
          state_d = fbp_pkg::ST_IDLE;
        end
      end
      default: state_d = fbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fbp_pkg::ST_IDLE;
      step_q    <= fbp_pkg::STEP_X;
      ret_q     <= fbp_pkg::STEP_X;
      ret_vld_q <= 1'b0;
      stopped_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      ret_q     <= ret_d;
      ret_vld_q <= ret_vld_d;
      stopped_q <= stopped_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      oconf_q <= conf_q;
      ox_q    <= x_q[DIM_BITS-1:0];
      oy_q    <= y_q[DIM_BITS-1:0];
      ow_q    <= w_q[DIM_BITS:0];
      oh_q    <= h_q[DIM_BITS:0];
    end
  end

  assign out_valid_o      = out_vld_q;
  assign box_confidence_o = oconf_q;
  assign box_x_o          = ox_q;
  assign box_y_o          = oy_q;
  assign box_width_o      = ow_q;
  assign box_height_o     = oh_q;

  a_square_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (box_width_o == box_height_o) && (box_width_o != '0))
    else $error("emitted box is not a non-empty square");

  a_box_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((DIM_BITS+2)'(box_x_o) + (DIM_BITS+2)'(box_width_o)
                     <= (DIM_BITS+2)'(wlim_q)))
    else $error("emitted box exceeds frame width");

  a_stopped_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stopped_q && !frame_start_i) |=> (state_q == fbp_pkg::ST_IDLE) && stopped_q)
    else $error("record of a stopped frame was processed");

  a_retire_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_vld_q |-> (state_q == fbp_pkg::ST_MUL || state_q == fbp_pkg::ST_RET))
    else $error("product retired outside the multiply sequence");

endmodule
